// ----- rtl/core/lmad_pkg.sv -----
// shared constants for the line mean absolute difference unit
package lmad_pkg;

    localparam int CFG_W = 13;
    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;
    localparam int MEAN_W = 24;
    localparam int TIME_W = 48;
    localparam int FRAC_BITS = 8;

endpackage

// ----- rtl/core/lmad_in_if.sv -----
// pixel input channel
interface lmad_in_if #(
    parameter int PIXEL_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic [PIXEL_BITS-1:0]         pixel_value;
    logic [lmad_pkg::TIME_W-1:0]   line_time;

    modport source (output valid, output pixel_value, output line_time, input ready);
    modport sink (input valid, input pixel_value, input line_time, output ready);
endinterface

// ----- rtl/core/lmad_out_if.sv -----
// line result output channel
interface lmad_out_if;
    logic                          valid;
    logic                          ready;
    logic [lmad_pkg::MEAN_W-1:0]   mean_abs_diff;
    logic [lmad_pkg::TIME_W-1:0]   line_stamp;

    modport source (output valid, output mean_abs_diff, output line_stamp, input ready);
    modport sink (input valid, input mean_abs_diff, input line_stamp, output ready);
endinterface

// ----- rtl/core/lmad_cfg_if.sv -----
// configuration write channel
interface lmad_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lmad_pkg::CFG_W-1:0]    elements_per_line;

    modport source (output valid, output elements_per_line, input ready);
    modport sink (input valid, input elements_per_line, output ready);
endinterface

// ----- rtl/core/line_mean_abs_difference_unit.sv -----
// top level of the line mean absolute difference unit
// Takes one pixel per cycle and compares it with the same element of the
// previous line, held in a line store ram with a registered read. At the last
// element of a line the summed difference goes to a bit-serial divider that
// then holds the result until it is taken. Pixels stream at one per cycle;
// the last element of a line is held off only while the previous line's
// result is still on its way into or through the divider, or not yet taken.
// The line store needs no clearing after reset.
module line_mean_abs_difference_unit #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int PIXEL_BITS   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lmad_in_if.sink    i_pixel,
    lmad_cfg_if.sink   i_cfg,
    lmad_out_if.source o_result
);

    localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int SUM_W  = PIXEL_BITS + $clog2(MAX_ELEMENTS);
    localparam int DVD_W  = SUM_W + lmad_pkg::FRAC_BITS;
    localparam int LEN_W  = (CNT_W > lmad_pkg::CFG_W) ? CNT_W : lmad_pkg::CFG_W;

    logic [lmad_pkg::CFG_W-1:0]  r_epl;
    logic [IDX_W-1:0]            r_idx;
    logic                        r_have_prev;
    logic [SUM_W-1:0]            r_sum;
    logic [SUM_W-1:0]            n_sum;

    logic                        r_s1_valid;
    logic                        r_s1_last;
    logic                        r_s1_use;
    logic [PIXEL_BITS-1:0]       r_s1_pix;
    logic [CNT_W-1:0]            r_s1_cnt;
    logic [lmad_pkg::TIME_W-1:0] r_s1_stamp;

    logic                        acc;
    logic [CNT_W-1:0]            count0;
    logic [LEN_W-1:0]            len_cfg;
    logic [LEN_W-1:0]            len_n;
    logic                        last0;
    logic [PIXEL_BITS-1:0]       old_pix;
    logic [PIXEL_BITS-1:0]       diff;
    logic                        div_start;
    logic                        div_busy;

    // line length clamped to 1..MAX_ELEMENTS
    assign len_cfg = LEN_W'(r_epl);
    always_comb begin
        if (len_cfg == '0) begin
            len_n = LEN_W'(1);
        end else if (len_cfg > LEN_W'(MAX_ELEMENTS)) begin
            len_n = LEN_W'(MAX_ELEMENTS);
        end else begin
            len_n = len_cfg;
        end
    end

    assign count0 = CNT_W'(r_idx) + CNT_W'(1);
    assign last0  = LEN_W'(count0) >= len_n;

    assign i_pixel.ready = !(last0 && (div_busy || (r_s1_valid && r_s1_last)));
    assign acc           = i_pixel.valid && i_pixel.ready;
    assign i_cfg.ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epl <= lmad_pkg::CFG_RESET;
        end else if (i_cfg.valid) begin
            r_epl <= i_cfg.elements_per_line;
        end
    end

    lmad_line_store #(
        .DEPTH  (MAX_ELEMENTS),
        .ADDR_W (IDX_W),
        .DATA_W (PIXEL_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (acc),
        .i_addr  (r_idx),
        .i_wdata (i_pixel.pixel_value),
        .o_rdata (old_pix)
    );

    // element position and first-line flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_have_prev <= 1'b0;
            r_s1_valid  <= 1'b0;
        end else begin
            r_s1_valid <= acc;
            if (acc) begin
                r_idx <= last0 ? '0 : count0[IDX_W-1:0];
                if (last0) begin
                    r_have_prev <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pix   <= i_pixel.pixel_value;
            r_s1_last  <= last0;
            r_s1_use   <= r_have_prev;
            r_s1_cnt   <= count0;
            r_s1_stamp <= i_pixel.line_time;
        end
    end

    // accumulate absolute difference
    always_comb begin
        if (!r_s1_use) begin
            diff = '0;
        end else if (old_pix > r_s1_pix) begin
            diff = old_pix - r_s1_pix;
        end else begin
            diff = r_s1_pix - old_pix;
        end
    end

    assign n_sum     = r_sum + SUM_W'(diff);
    assign div_start = r_s1_valid && r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (r_s1_valid) begin
            r_sum <= r_s1_last ? '0 : n_sum;
        end
    end

    lmad_divider #(
        .DVD_W (DVD_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({n_sum, {lmad_pkg::FRAC_BITS{1'b0}}}),
        .i_divisor  (r_s1_cnt),
        .i_stamp    (r_s1_stamp),
        .o_busy     (div_busy),
        .o_result   (o_result)
    );

`ifndef ASSERT_OFF
    a_sum_first_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have_prev |-> r_sum == '0)
        else $error("difference summed before a previous line exists");
    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_last |=> r_sum == '0)
        else $error("sum not cleared at end of line");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_idx) < CNT_W'(MAX_ELEMENTS))
        else $error("element position beyond line store");
`endif

endmodule

// ----- rtl/core/lmad_line_store.sv -----
// previous line store, read-first synchronous ram
module lmad_line_store #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/lmad_divider.sv -----
// bit-serial restoring divider producing the line mean and holding the result
module lmad_divider #(
    parameter int DVD_W = 36,
    parameter int CNT_W = 13
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [DVD_W-1:0]            i_dividend,
    input  logic [CNT_W-1:0]            i_divisor,
    input  logic [lmad_pkg::TIME_W-1:0] i_stamp,
    output logic                        o_busy,
    lmad_out_if.source                  o_result
);

    localparam int STEP_W = $clog2(DVD_W);
    localparam int QX_W = (DVD_W > lmad_pkg::MEAN_W) ? DVD_W : lmad_pkg::MEAN_W;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    logic [STEP_W-1:0]           r_step;
    logic [CNT_W-1:0]            r_rem;
    logic [CNT_W-1:0]            r_div;
    logic [DVD_W-1:0]            r_q;
    logic [lmad_pkg::TIME_W-1:0] r_stamp;

    logic [CNT_W:0]              rem_sh;
    logic                        rem_ge;
    logic [CNT_W:0]              n_rem;
    logic [QX_W-1:0]             q_ext;

    assign rem_sh = {r_rem, r_q[DVD_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_div};
    assign n_rem  = rem_ge ? (rem_sh - {1'b0, r_div}) : rem_sh;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_step == LAST_STEP) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (o_result.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_step  <= '0;
            r_rem   <= '0;
            r_div   <= i_divisor;
            r_q     <= i_dividend;
            r_stamp <= i_stamp;
        end else if (r_state == ST_RUN) begin
            r_step <= r_step + STEP_W'(1);
            r_rem  <= n_rem[CNT_W-1:0];
            r_q    <= {r_q[DVD_W-2:0], rem_ge};
        end
    end

    assign q_ext                  = QX_W'(r_q);
    assign o_busy                 = r_state != ST_IDLE;
    assign o_result.valid         = r_state == ST_DONE;
    assign o_result.mean_abs_diff = q_ext[lmad_pkg::MEAN_W-1:0];
    assign o_result.line_stamp    = r_stamp;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == ST_IDLE)
        else $error("divider started while busy");
    a_done_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) && (r_step == LAST_STEP) |=> r_state == ST_DONE)
        else $error("divider did not finish after last step");
`endif

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for line_mean_abs_difference_unit, predicting each line mean and stamp
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEAN_W = lmad_pkg::MEAN_W;
    localparam int TIME_W = lmad_pkg::TIME_W;
    localparam int CFG_W = lmad_pkg::CFG_W;
    localparam int FRAC_BITS = lmad_pkg::FRAC_BITS;
    localparam logic [CFG_W-1:0] CFG_RESET = lmad_pkg::CFG_RESET;

    localparam int MAX_ELEMENTS = 4096;
    localparam int PIXEL_BITS = 16;
    localparam int FIRST_SPLIT = 100;
    localparam int FIRST_LEN = 320;
    localparam int LONG_PART = 150;
    localparam int RANDOM_ITEMS = 850;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [TIME_W-1:0] stamp;
    } t_line_result;

    typedef enum int {FILL_RANDOM, FILL_NEAR, FILL_EXTREME} t_fill_kind;

    logic i_clk;
    logic i_rst_n;

    lmad_in_if #(.PIXEL_BITS(PIXEL_BITS)) pix_if ();
    lmad_cfg_if cfg_if ();
    lmad_out_if res_if ();

    line_mean_abs_difference_unit #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .PIXEL_BITS(PIXEL_BITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_pixel(pix_if),
        .i_cfg(cfg_if),
        .o_result(res_if)
    );

    bit src_idle_on = 1'b1;
    bit sink_stall_on = 1'b1;
    int mismatch_count = 0;
    int cycle_count = 0;

    // line store and accumulator of the predictor
    logic [PIXEL_BITS-1:0] prev_line_px [0:MAX_ELEMENTS-1];
    bit have_prev_line = 1'b0;
    bit [39:0] diff_total = '0;
    int elem_pos = 0;
    logic [CFG_W-1:0] line_len_reg = CFG_RESET;

    t_line_result pending_means[$];
    t_line_result oldest_mean;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        forever begin
            if (sink_stall_on && $urandom_range(0, 9) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_means.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: mean %0d stamp %0h",
                             res_if.mean_abs_diff, res_if.line_stamp);
            end else begin
                oldest_mean = pending_means.pop_front();
                if (res_if.mean_abs_diff !== oldest_mean.mean ||
                    res_if.line_stamp !== oldest_mean.stamp) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: mean exp %0d got %0d, stamp exp %0h got %0h",
                                 oldest_mean.mean, res_if.mean_abs_diff,
                                 oldest_mean.stamp, res_if.line_stamp);
                end
            end
        end
    end

    task automatic predict_pixel(input logic [PIXEL_BITS-1:0] pix,
                                 input logic [TIME_W-1:0] stamp);
        int span;
        bit [39:0] quot;
        t_line_result r;
        if (line_len_reg == 0)
            span = 1;
        else if (line_len_reg > MAX_ELEMENTS)
            span = MAX_ELEMENTS;
        else
            span = int'(line_len_reg);
        if (have_prev_line)
            diff_total += 40'((prev_line_px[elem_pos] > pix) ? prev_line_px[elem_pos] - pix
                                                             : pix - prev_line_px[elem_pos]);
        prev_line_px[elem_pos] = pix;
        if (elem_pos + 1 < span) begin
            elem_pos++;
        end else begin
            quot = (diff_total << FRAC_BITS) / 40'(elem_pos + 1);
            r.mean = quot[MEAN_W-1:0];
            r.stamp = stamp;
            pending_means.insert(pending_means.size(), r);
            diff_total = '0;
            elem_pos = 0;
            have_prev_line = 1'b1;
        end
    endtask

    function automatic logic [TIME_W-1:0] rand_stamp();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[TIME_W-1:0];
    endfunction

    function automatic logic [PIXEL_BITS-1:0] pick_pixel(input t_fill_kind fill);
        int v;
        case (fill)
            FILL_NEAR: begin
                v = int'(prev_line_px[elem_pos]) + int'($urandom_range(0, 600)) - 300;
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
                return v[PIXEL_BITS-1:0];
            end
            FILL_EXTREME: return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return PIXEL_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix,
                              input logic [TIME_W-1:0] stamp);
        if (src_idle_on && $urandom_range(0, 7) == 0) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel_value <= pix;
        pix_if.line_time <= stamp;
        do @(posedge i_clk); while (!pix_if.ready);
        predict_pixel(pix, stamp);
    endtask

    task automatic send_fill(input int count, input t_fill_kind fill);
        for (int i = 0; i < count; i++)
            send_pixel(pick_pixel(fill), rand_stamp());
    endtask

    task automatic drain_results();
        pix_if.valid <= 1'b0;
        while (pending_means.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_line_length(input logic [CFG_W-1:0] len_val);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.elements_per_line <= len_val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        line_len_reg = len_val;
    endtask

    // first line after reset gives a zero mean with no previous line, then a full-swing line
    task automatic test_first_line_at_reset();
        for (int i = 0; i < FIRST_SPLIT; i++)
            send_pixel('1, rand_stamp());
        write_line_length(CFG_W'(FIRST_LEN));
        for (int i = FIRST_SPLIT; i < FIRST_LEN; i++)
            send_pixel('1, (i == FIRST_LEN - 1) ? '0 : rand_stamp());
        for (int i = 0; i < FIRST_LEN; i++)
            send_pixel('0, (i == FIRST_LEN - 1) ? '1 : rand_stamp());
    endtask

    task automatic test_short_lines();
        write_line_length('0);
        send_pixel('1, '0);
        send_pixel('0, '1);
        write_line_length(CFG_W'(3));
        send_pixel('0, rand_stamp());
        send_pixel('1, rand_stamp());
        send_pixel(16'h8000, rand_stamp());
        send_pixel('1, rand_stamp());
        send_pixel('0, rand_stamp());
        send_pixel(16'h7fff, '1);
    endtask

    task automatic test_mid_line_change();
        write_line_length(CFG_W'(6));
        send_fill(4, FILL_RANDOM);
        write_line_length(CFG_W'(2));
        send_fill(1, FILL_EXTREME);
        write_line_length(CFG_W'(5));
        send_fill(2, FILL_NEAR);
        write_line_length(CFG_W'(12));
        send_fill(10, FILL_RANDOM);
    endtask

    task automatic test_long_lines();
        write_line_length('1);
        send_fill(LONG_PART, FILL_RANDOM);
        write_line_length(CFG_W'(LONG_PART / 2));
        send_fill(1, FILL_NEAR);
        write_line_length(CFG_W'(MAX_ELEMENTS));
        send_fill(LONG_PART, FILL_NEAR);
    endtask

    task automatic test_random_lines();
        int sent_here;
        int span;
        int lines;
        int partial;
        bit quiet;
        logic [CFG_W-1:0] len_val;
        sent_here = 0;
        while (sent_here < RANDOM_ITEMS) begin
            quiet = sent_here > RANDOM_ITEMS * 17 / 20;
            src_idle_on = !quiet && $urandom_range(0, 3) != 0;
            sink_stall_on = !quiet && $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 15))
                0: len_val = '0;
                1: len_val = CFG_W'($urandom_range(100, 300));
                default: len_val = CFG_W'($urandom_range(1, 24));
            endcase
            write_line_length(len_val);
            span = (len_val == 0) ? 1 : int'(len_val);
            lines = $urandom_range(1, 5);
            repeat (lines)
                send_fill(span, t_fill_kind'($urandom_range(0, 2)));
            sent_here += lines * span;
            // leave a line unfinished so the next length lands mid line
            if (span > 1 && $urandom_range(0, 3) == 0) begin
                partial = $urandom_range(1, span - 1);
                send_fill(partial, FILL_RANDOM);
                sent_here += partial;
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        pix_if.valid <= 1'b0;
        pix_if.pixel_value <= '0;
        pix_if.line_time <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.elements_per_line <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_first_line_at_reset();
        test_short_lines();
        test_mid_line_change();
        test_long_lines();
        test_random_lines();
        drain_results();
        mismatch_count += pending_means.size();
        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/lmad_pkg.sv
rtl/core/lmad_in_if.sv
rtl/core/lmad_out_if.sv
rtl/core/lmad_cfg_if.sv
rtl/core/lmad_line_store.sv
rtl/core/lmad_divider.sv
rtl/core/line_mean_abs_difference_unit.sv
tb/tb_top.sv
